### rtl/core/positional_list_engine_assert.svh
// ----------------------------------------------------------------------------
// positional_list_engine_assert.svh
// Assertion macros shared by the positional list engine RTL.
// ----------------------------------------------------------------------------
`ifndef POSITIONAL_LIST_ENGINE_ASSERT_SVH
`define POSITIONAL_LIST_ENGINE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define PLE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("positional_list_engine: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define PLE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("positional_list_engine: next-cycle check failed");

`endif

### rtl/core/ple_pkg.sv
// ----------------------------------------------------------------------------
// ple_pkg
// Types and constants shared by the positional list engine modules.
// ----------------------------------------------------------------------------
`default_nettype none

package ple_pkg;

   localparam int PLE_DEPTH  = 16;
   localparam int DATA_W     = 32;
   localparam int OP_W       = 3;
   localparam int POS_W      = 8;
   localparam int RSP_LEN_W  = 5;

   typedef enum logic [OP_W-1:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_POS   = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_POS   = 3'd5,
      OP_DUMP      = 3'd6
   } ple_op_type;

   typedef enum logic [1:0] {
      STAT_OK     = 2'd0,
      STAT_EMPTY  = 2'd1,
      STAT_BADPOS = 2'd2,
      STAT_FULL   = 2'd3
   } ple_status_type;

   typedef enum logic {
      PLE_IDLE = 1'b0,
      PLE_DUMP = 1'b1
   } ple_state_type;

   // Controller to datapath.
   typedef struct packed {
      logic accept;       // request beat taken: apply the operation
      logic load_single;  // load the one-beat response for this request
      logic dump_step;    // emit the front cell and rotate the list
   } ple_cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic list_empty;   // no elements held
      logic dump_final;   // current dump beat is the last one
   } ple_sts_type;

endpackage

`default_nettype wire

### rtl/core/ple_ctrl.sv
// ----------------------------------------------------------------------------
// ple_ctrl
// Sequencer for the positional list engine: handshakes and dump walk.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_ctrl
   import ple_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire logic [OP_W-1:0]   req_opcode,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output ple_cmd_type            cmd,
   input  wire ple_sts_type       sts
);

   ple_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;
   logic          slot_free;
   logic          accept;
   logic          load;

   assign slot_free = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      accept    = 1'b0;
      load      = 1'b0;
      cmd       = '0;
      case (state_ff)
         PLE_IDLE: begin
            req_ready  = slot_free;
            accept     = req_valid && slot_free;
            cmd.accept = accept;
            if (accept) begin
               if ((req_opcode == OP_DUMP) && !sts.list_empty) begin
                  state_in = PLE_DUMP;
               end else begin
                  cmd.load_single = 1'b1;
                  load            = 1'b1;
               end
            end
         end
         PLE_DUMP: begin
            if (slot_free) begin
               cmd.dump_step = 1'b1;
               load          = 1'b1;
               if (sts.dump_final) begin
                  state_in = PLE_IDLE;
               end
            end
         end
         default: begin
            state_in = PLE_IDLE;
         end
      endcase
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= PLE_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

### rtl/core/ple_datapath.sv
// ----------------------------------------------------------------------------
// ple_datapath
// Cell chain, length counter, dump counter and response register.
// ----------------------------------------------------------------------------
`default_nettype none

module ple_datapath
   import ple_pkg::*;
#(
   parameter int DEPTH = PLE_DEPTH
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic [OP_W-1:0]          req_opcode,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic [POS_W-1:0]         req_position,
   output logic [1:0]                    rsp_status,
   output logic signed [DATA_W-1:0]      rsp_element,
   output logic                          rsp_last,
   output logic [RSP_LEN_W-1:0]          rsp_length,
   input  wire ple_cmd_type              cmd,
   output ple_sts_type                   sts
);

   localparam int LW = $clog2(DEPTH + 1);
   localparam int CW = ((LW > POS_W) ? LW : POS_W) + 1;

   logic signed [DATA_W-1:0] cells_ff [DEPTH];
   logic signed [DATA_W-1:0] cells_in [DEPTH];
   logic [LW-1:0]            len_ff, len_in;
   logic [LW-1:0]            cnt_ff, cnt_in;

   ple_status_type           status_ff, status_in;
   logic signed [DATA_W-1:0] element_ff, element_in;
   logic                     last_ff, last_in;
   logic [RSP_LEN_W-1:0]     length_ff, length_in;

   ple_op_type     op;
   ple_status_type op_status;
   logic [CW-1:0]  pos_w, len_w, idx;
   logic           do_ins, do_del;

   assign sts.list_empty = (len_ff == '0);
   assign sts.dump_final = (cnt_ff == (len_ff - LW'(1)));

   // Decode the request against the current length.
   always_comb begin
      op        = ple_op_type'(req_opcode);
      pos_w     = CW'(req_position);
      len_w     = CW'(len_ff);
      op_status = STAT_OK;
      do_ins    = 1'b0;
      do_del    = 1'b0;
      idx       = '0;
      case (op)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
            if (len_w == CW'(DEPTH)) begin
               op_status = STAT_FULL;
            end else if ((op == OP_INS_POS) &&
                         ((pos_w == '0) || (pos_w > (len_w + CW'(1))))) begin
               op_status = STAT_BADPOS;
            end else begin
               do_ins = 1'b1;
               if (op == OP_INS_FRONT) begin
                  idx = '0;
               end else if (op == OP_INS_BACK) begin
                  idx = len_w;
               end else begin
                  idx = pos_w - CW'(1);
               end
            end
         end
         OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
            if (len_w == '0) begin
               op_status = STAT_EMPTY;
            end else if ((op == OP_DEL_POS) &&
                         ((pos_w == '0) || (pos_w > len_w))) begin
               op_status = STAT_BADPOS;
            end else begin
               do_del = 1'b1;
               if (op == OP_DEL_FRONT) begin
                  idx = '0;
               end else if (op == OP_DEL_BACK) begin
                  idx = len_w - CW'(1);
               end else begin
                  idx = pos_w - CW'(1);
               end
            end
         end
         OP_DUMP: begin
            if (len_w == '0) begin
               op_status = STAT_EMPTY;
            end
         end
         default: begin
            op_status = STAT_OK;
         end
      endcase
   end

   // Cell chain: every cell picks from itself, a neighbor, the front or the new value.
   always_comb begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_in[i] = cells_ff[i];
      end
      len_in = len_ff;
      if (cmd.accept && do_ins) begin
         if (idx == '0) begin
            cells_in[0] = req_value;
         end
         for (int i = 1; i < DEPTH; i++) begin
            if (CW'(i) > idx) begin
               cells_in[i] = cells_ff[i-1];
            end else if (CW'(i) == idx) begin
               cells_in[i] = req_value;
            end
         end
         len_in = len_ff + LW'(1);
      end else if (cmd.accept && do_del) begin
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (CW'(i) >= idx) begin
               cells_in[i] = cells_ff[i+1];
            end
         end
         len_in = len_ff - LW'(1);
      end else if (cmd.dump_step) begin
         // Rotate the held elements by one so the next one reaches the front.
         for (int i = 0; i < DEPTH - 1; i++) begin
            if (CW'(i) == (len_w - CW'(1))) begin
               cells_in[i] = cells_ff[0];
            end else begin
               cells_in[i] = cells_ff[i+1];
            end
         end
         if (CW'(DEPTH - 1) == (len_w - CW'(1))) begin
            cells_in[DEPTH-1] = cells_ff[0];
         end
      end
   end

   // Response register and dump counter.
   always_comb begin
      status_in  = status_ff;
      element_in = element_ff;
      last_in    = last_ff;
      length_in  = length_ff;
      cnt_in     = cnt_ff;
      if (cmd.accept) begin
         cnt_in = '0;
      end
      if (cmd.load_single) begin
         status_in  = op_status;
         element_in = '0;
         last_in    = 1'b1;
         length_in  = RSP_LEN_W'(len_in);
      end else if (cmd.dump_step) begin
         status_in  = STAT_OK;
         element_in = cells_ff[0];
         last_in    = sts.dump_final;
         length_in  = RSP_LEN_W'(len_ff);
         cnt_in     = cnt_ff + LW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff <= '0;
         cnt_ff <= '0;
      end else begin
         len_ff <= len_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < DEPTH; i++) begin
         cells_ff[i] <= cells_in[i];
      end
      status_ff  <= status_in;
      element_ff <= element_in;
      last_ff    <= last_in;
      length_ff  <= length_in;
   end

   assign rsp_status  = status_ff;
   assign rsp_element = element_ff;
   assign rsp_last    = last_ff;
   assign rsp_length  = length_ff;

endmodule

`default_nettype wire

### rtl/core/positional_list_engine.sv
// ----------------------------------------------------------------------------
// positional_list_engine
// Ordered list of up to DEPTH signed 32-bit values with positional insert,
// delete and a front-to-back dump.
// ----------------------------------------------------------------------------
//
//   channel  prefix  dir  beat contents
//   -------  ------  ---  -------------------------------------------------
//   request  req_    in   opcode, value, 1-based position
//   response rsp_    out  status, element, last mark, length after the op
//
// An insert, a delete, an empty dump or an unused opcode yields one response
// beat. A dump of N elements holds off requests until the dump walk has sent
// all N beats, one beat per cycle while the response is not stalled; the walk
// rotates the cell chain so each element in turn reaches the front cell.
// Reset clears the length and the handshake state; cell contents stay as is.
// A stalled response holds everything: no request is taken and the dump walk
// pauses until the response register frees up.
// ----------------------------------------------------------------------------
`default_nettype none

`include "positional_list_engine_assert.svh"

module positional_list_engine
   import ple_pkg::*;
#(
   parameter int DEPTH = PLE_DEPTH
)
(
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [OP_W-1:0]          req_opcode,
   input  wire logic signed [DATA_W-1:0] req_value,
   input  wire logic [POS_W-1:0]         req_position,
   // response channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output logic [1:0]                    rsp_status,
   output logic signed [DATA_W-1:0]      rsp_element,
   output logic                          rsp_last,
   output logic [RSP_LEN_W-1:0]          rsp_length
);

   // Command and status between sequencer and datapath.
   ple_cmd_type cmd;
   ple_sts_type sts;

   // Sequencer: owns the handshakes, the response valid and the dump walk.
   ple_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_opcode (req_opcode),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .cmd        (cmd),
      .sts        (sts)
   );

   // Datapath: cell chain, length, dump counter and response payload.
   ple_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock        (clock),
      .reset        (reset),
      .req_opcode   (req_opcode),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_status   (rsp_status),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last),
      .rsp_length   (rsp_length),
      .cmd          (cmd),
      .sts          (sts)
   );

   // Drop request acceptance while the dump walk owns the response register.
   `PLE_ASSERT_IMPLIES(a_no_req_during_dump, clock, reset, cmd.dump_step, !req_ready)

   // A delete on an empty list answers with an empty status in the next beat.
   `PLE_ASSERT_NEXT(a_del_empty_status, clock, reset, req_valid && req_ready && sts.list_empty && ((req_opcode == OP_DEL_FRONT) || (req_opcode == OP_DEL_BACK) || (req_opcode == OP_DEL_POS)), rsp_valid && (rsp_status == STAT_EMPTY))

   // A non-empty dump starts the walk: no beat yet, and requests held off.
   `PLE_ASSERT_NEXT(a_dump_start, clock, reset, req_valid && req_ready && !sts.list_empty && (req_opcode == OP_DUMP), !rsp_valid && !req_ready)

   // A full report always carries the full length.
   `PLE_ASSERT_IMPLIES(a_full_length, clock, reset, rsp_valid && (rsp_status == STAT_FULL), rsp_length == RSP_LEN_W'(DEPTH))

endmodule

`default_nettype wire

### tb/tb_positional_list_engine.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_positional_list_engine
// Self-checking bench for the positional list engine. A queue-based copy of
// the list predicts every response beat; directed cases cover the empty and
// full corners and bad positions, then random insert/delete/dump traffic
// runs the list up and down between empty and full, with random stalls on
// both channels and a final stretch at full rate.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_positional_list_engine;
   import ple_pkg::*;

   localparam int          LIST_DEPTH  = PLE_DEPTH;
   localparam int          CYCLE_LIMIT = 200000;
   localparam int          DRAIN_WAIT  = 20;
   // Opcode with no operation behind it: the engine answers ok and leaves the
   // list alone.
   localparam logic [2:0]  OP_UNUSED   = 3'd7;
   localparam logic [31:0] VAL_MAX     = 32'h7fff_ffff;
   localparam logic [31:0] VAL_MIN     = 32'h8000_0000;

   // One response beat as the engine should produce it.
   typedef struct packed {
      ple_status_type     status;
      logic signed [31:0] element;
      logic               last;
      logic [4:0]         length;
   } list_beat_type;

   logic                         clock        = 1'b0;
   logic                         reset        = 1'b1;
   logic                         req_valid    = 1'b0;
   logic                         req_ready;
   logic [OP_W-1:0]              req_opcode   = '0;
   logic signed [DATA_W-1:0]     req_value    = '0;
   logic [POS_W-1:0]             req_position = '0;
   logic                         rsp_valid;
   logic                         rsp_ready    = 1'b0;
   logic [1:0]                   rsp_status;
   logic signed [DATA_W-1:0]     rsp_element;
   logic                         rsp_last;
   logic [RSP_LEN_W-1:0]         rsp_length;

   // Shadow copy of the list, front at index 0, and the beats still owed.
   logic signed [31:0] list_model[$];
   list_beat_type      pending_beats[$];

   int unsigned fail_count  = 0;
   int unsigned cycle_count = 0;
   bit          idle_on     = 1'b1;   // random gaps on both channels
   bit          growing     = 1'b1;   // random traffic leans toward inserts

   positional_list_engine #(
      .DEPTH(LIST_DEPTH)
   ) uut (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_opcode   (req_opcode),
      .req_value    (req_value),
      .req_position (req_position),
      .rsp_valid    (rsp_valid),
      .rsp_ready    (rsp_ready),
      .rsp_status   (rsp_status),
      .rsp_element  (rsp_element),
      .rsp_last     (rsp_last),
      .rsp_length   (rsp_length)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // Watchdog: give up if the run does not finish well past its worst case.
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("positional_list_engine test failed");
      $finish;
   end

   // ------------------------------------------------------------------------
   // List predictor: apply one accepted request to the shadow list and queue
   // the response beats it must produce.
   // ------------------------------------------------------------------------
   function automatic void apply_list_op(logic [2:0] op, logic signed [31:0] val,
                                         logic [7:0] pos);
      ple_status_type st;
      int             len;
      list_beat_type  beat;
      st  = STAT_OK;
      len = list_model.size();
      case (op)
         OP_INS_FRONT, OP_INS_BACK, OP_INS_POS: begin
            // Full check wins over the position check.
            if (len >= LIST_DEPTH) st = STAT_FULL;
            else if (op == OP_INS_FRONT) list_model.push_front(val);
            else if (op == OP_INS_BACK) list_model.push_back(val);
            else if (pos == 0 || int'(pos) > len + 1) st = STAT_BADPOS;
            else list_model.insert(int'(pos) - 1, val);
         end
         OP_DEL_FRONT, OP_DEL_BACK, OP_DEL_POS: begin
            // Empty check wins over the position check.
            if (len == 0) st = STAT_EMPTY;
            else if (op == OP_DEL_FRONT) void'(list_model.pop_front());
            else if (op == OP_DEL_BACK) void'(list_model.pop_back());
            else if (pos == 0 || int'(pos) > len) st = STAT_BADPOS;
            else list_model.delete(int'(pos) - 1);
         end
         default: ;
      endcase
      if (op == OP_DUMP && len != 0) begin
         // One beat per element, front to back, last mark on the back one.
         for (int i = 0; i < len; i++) begin
            beat.status  = STAT_OK;
            beat.element = list_model[i];
            beat.last    = (i == len - 1);
            beat.length  = 5'(len);
            pending_beats.push_back(beat);
         end
      end else begin
         beat.status  = (op == OP_DUMP) ? STAT_EMPTY : st;
         beat.element = '0;
         beat.last    = 1'b1;
         beat.length  = 5'(list_model.size());
         pending_beats.push_back(beat);
      end
   endfunction

   // ------------------------------------------------------------------------
   // Request side: hold the beat until the engine takes it, predict, then
   // maybe drop valid for a random burst.
   // ------------------------------------------------------------------------
   task automatic send_list_op(input logic [2:0] op, input logic [31:0] val,
                               input logic [7:0] pos);
      req_valid    <= 1'b1;
      req_opcode   <= op;
      req_value    <= val;
      req_position <= pos;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      apply_list_op(op, val, pos);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
   endtask

   // Mostly random values, now and then an extreme one.
   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 11))
         0:       return VAL_MAX;
         1:       return VAL_MIN;
         2:       return 32'h0;
         3:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // ------------------------------------------------------------------------
   // Random traffic: a walk of the list length between empty and full, with
   // well-formed inserts and deletes most of the time, some dumps, and some
   // noise (bad positions, the unused opcode).
   // ------------------------------------------------------------------------
   task automatic run_random_items(input int count);
      int         len;
      int unsigned roll;
      logic [2:0] op;
      logic [7:0] pos;
      bit         do_insert;
      for (int n = 0; n < count; n++) begin
         len = list_model.size();
         if (len >= LIST_DEPTH) growing = 1'b0;
         else if (len == 0) growing = 1'b1;
         else if ($urandom_range(0, 19) == 0) growing = !growing;
         roll = $urandom_range(0, 99);
         pos  = 8'($urandom_range(0, 255));
         if (roll < 10) begin
            op = OP_DUMP;
         end else if (roll < 16) begin
            // Noise: the unused opcode or a position out of range.
            case ($urandom_range(0, 2))
               0: op = OP_UNUSED;
               1: begin
                  op  = OP_INS_POS;
                  pos = ($urandom_range(0, 1) == 0) ? 8'd0
                                                    : 8'($urandom_range(len + 2, 255));
               end
               default: begin
                  op  = OP_DEL_POS;
                  pos = ($urandom_range(0, 1) == 0) ? 8'd0
                                                    : 8'($urandom_range(len + 1, 255));
               end
            endcase
         end else begin
            do_insert = growing ? ($urandom_range(0, 9) < 7) : ($urandom_range(0, 9) < 3);
            case ($urandom_range(0, 2))
               0:       op = do_insert ? OP_INS_FRONT : OP_DEL_FRONT;
               1:       op = do_insert ? OP_INS_BACK : OP_DEL_BACK;
               default: op = do_insert ? OP_INS_POS : OP_DEL_POS;
            endcase
            if (op == OP_INS_POS) pos = 8'($urandom_range(1, len + 1));
            else if (op == OP_DEL_POS && len > 0) pos = 8'($urandom_range(1, len));
         end
         send_list_op(op, pick_value(), pos);
      end
   endtask

   // ------------------------------------------------------------------------
   // Response side: random stall bursts, then ready stretches of random
   // length; steady ready once idling is switched off.
   // ------------------------------------------------------------------------
   initial begin
      while (reset) @(posedge clock);
      forever begin
         if (idle_on && $urandom_range(0, 2) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge clock);
         end
         rsp_ready <= 1'b1;
         repeat ($urandom_range(1, 12)) @(posedge clock);
      end
   end

   // Compare every accepted response beat with the oldest prediction.
   always @(posedge clock) begin : check_rsp
      list_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_beats.size() == 0) begin
            $error("response beat with nothing expected");
            fail_count++;
         end else begin
            want = pending_beats.pop_front();
            if (rsp_status !== want.status) begin
               $error("status mismatch: expected %0d, actual %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_element !== want.element) begin
               $error("element mismatch: expected %0d, actual %0d",
                      want.element, rsp_element);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last mismatch: expected %0d, actual %0d", want.last, rsp_last);
               fail_count++;
            end
            if (rsp_length !== want.length) begin
               $error("length mismatch: expected %0d, actual %0d", want.length, rsp_length);
               fail_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Empty list: dump gives one empty beat, delete reports empty even with a
   // bad position, insert at position 0 is a bad position.
   task automatic test_empty_list();
      send_list_op(OP_DUMP, 32'h0, 8'd0);
      send_list_op(OP_DEL_POS, 32'h0, 8'd0);
      send_list_op(OP_DEL_FRONT, 32'h0, 8'd1);
      send_list_op(OP_INS_POS, 32'h1234_5678, 8'd0);
   endtask

   // Fill through every insert flavor, then insert into the full list (full
   // wins over the bad position) and dump all sixteen elements.
   task automatic test_fill_to_full();
      logic [2:0] op;
      int         len;
      send_list_op(OP_INS_FRONT, VAL_MAX, 8'd0);
      send_list_op(OP_INS_BACK, VAL_MIN, 8'd255);
      send_list_op(OP_INS_POS, 32'hffff_ffff, 8'd2);
      send_list_op(OP_INS_POS, 32'h0, 8'd1);
      send_list_op(OP_INS_POS, 32'h5a5a_a5a5, 8'd5);
      while (list_model.size() < LIST_DEPTH) begin
         len = list_model.size();
         case (len % 3)
            0:       op = OP_INS_FRONT;
            1:       op = OP_INS_BACK;
            default: op = OP_INS_POS;
         endcase
         send_list_op(op, $urandom, 8'($urandom_range(1, len + 1)));
      end
      send_list_op(OP_INS_POS, 32'hdead_beef, 8'd0);
      send_list_op(OP_DUMP, 32'h0, 8'd0);
   endtask

   // Delete positions out of range on a full list, a valid delete of the
   // back slot by position, and the unused opcode.
   task automatic test_bad_delete_position();
      send_list_op(OP_DEL_POS, 32'h0, 8'd0);
      send_list_op(OP_DEL_POS, 32'h0, 8'(LIST_DEPTH + 1));
      send_list_op(OP_DEL_POS, 32'h0, 8'd255);
      send_list_op(OP_DEL_POS, 32'h0, 8'(LIST_DEPTH));
      send_list_op(OP_UNUSED, 32'hffff_ffff, 8'd255);
   endtask

   task automatic test_random_traffic();
      run_random_items(143);
   endtask

   // Last stretch with both sides at full rate.
   task automatic test_streaming();
      idle_on = 1'b0;
      run_random_items(40);
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_list();
      test_fill_to_full();
      test_bad_delete_position();
      test_random_traffic();
      test_streaming();
      req_valid <= 1'b0;

      // Drain every owed beat, then watch for strays.
      while (pending_beats.size() != 0) @(posedge clock);
      repeat (DRAIN_WAIT) @(posedge clock);

      if (fail_count == 0) begin
         $display("positional_list_engine test passed");
      end else begin
         $display("positional_list_engine test failed");
      end
      $finish;
   end

endmodule

`default_nettype wire
